>>> hdl/generation_tagged_lease_table_macros.svh
// Assertion macros for the lease table checker.
// Expects signals clk and arst_n in the scope of use; no other dependencies.
`ifndef GENERATION_TAGGED_LEASE_TABLE_MACROS_SVH
`define GENERATION_TAGGED_LEASE_TABLE_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define GTL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define GTL_ASSERT_NEVER(label, expr, msg) \
	`GTL_ASSERT(label, !(expr), msg)

`endif

>>> hdl/gtl_pkg.sv
// Shared types and constants for the generation-tagged lease table.
// No dependencies; used by every module of the block.
`default_nettype none

package gtl_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int IN_W           = 104;
	localparam int OUT_W          = 104;
	localparam int FIELDS_IN_W    = 98;
	localparam int FIELDS_OUT_W   = 99;
	localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ACT_ACQUIRE = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_SET     = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_NO_HANDLE = 3'd1,
		STS_EXHAUSTED = 3'd2,
		STS_FULL      = 3'd3,
		STS_STALE     = 3'd4,
		STS_REFUSED   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// Request travelling along the slot chain.
	typedef struct packed {
		logic        vld;
		logic        acq;
		logic        hit;
		logic [31:0] token;
		logic [31:0] epoch;
		logic [31:0] handle;
	} query_t;

endpackage

`default_nettype wire

>>> hdl/generation_tagged_lease_table.sv
// Generation-tagged lease table: top level with request control and the slot chain.
// Depends on gtl_pkg and gtl_cell.
//
// Usage:
//   Requests enter on the s_axis channel, one item per request; each request gives
//   exactly one result item on the m_axis channel, in order.
//   Acquire and release walk the chain of SLOT_COUNT slot cells, one cell per cycle,
//   lowest slot first; the first free slot (acquire) or first matching busy slot
//   (release) takes the request and marks it hit for the cells further down.
//   Acquire/release pass from accept through the launch register, the SLOT_COUNT
//   cells and the result stage to the result; set-handle, action code three and
//   acquires refused up front go straight to the result stage. Only one request is in
//   flight: intake stays closed until the previous result has left the result stage.
//   s_axis_tready is high only while idle. The result sits in an output register;
//   a new request may be accepted while it waits. If the receiver stalls, the next
//   result holds in the result stage and no further request is taken until the
//   output register frees.
//   Reset (arst_n low) empties all slots, sets the next token to 1, the epoch and
//   current handle to 0, and drops any pending result.
`default_nettype none

module generation_tagged_lease_table #(
	parameter int SLOT_COUNT = gtl_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	// [1:0] action, [33:2] lease_token_in, [65:34] lease_epoch_in,
	// [97:66] handle_in, rest zero
	input  wire logic [gtl_pkg::IN_W-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	// [2:0] status, [34:3] lease_token_out, [66:35] lease_epoch_out,
	// [98:67] handle_out, rest zero
	output logic [gtl_pkg::OUT_W-1:0]     m_axis_tdata
);

	gtl_pkg::state_t  state_q, state_nxt;
	gtl_pkg::query_t  query_q;
	gtl_pkg::query_t  chain [SLOT_COUNT+1];
	logic [SLOT_COUNT-1:0] busy_vec;

	logic [31:0] token_ctr_q;
	logic [31:0] cur_epoch_q;
	logic [31:0] cur_handle_q;

	gtl_pkg::status_t res_status_q;
	logic [31:0]      res_token_q;
	logic [31:0]      res_epoch_q;
	logic [31:0]      res_handle_q;

	logic                     out_vld_q;
	logic [gtl_pkg::OUT_W-1:0] out_data_q;

	logic [1:0]  in_action;
	logic [31:0] in_token;
	logic [31:0] in_epoch;
	logic [31:0] in_handle;

	logic accept;
	logic launch;
	logic any_busy;
	logic chain_done;
	logic load_out;
	gtl_pkg::status_t imm_status;

	// Unpack the request.
	assign in_action = s_axis_tdata[1:0];
	assign in_token  = s_axis_tdata[33:2];
	assign in_epoch  = s_axis_tdata[65:34];
	assign in_handle = s_axis_tdata[97:66];

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign any_busy   = |busy_vec;
	assign chain_done = chain[SLOT_COUNT].vld;

	// Decide whether the request needs the chain or resolves here.
	always_comb begin
		launch     = 1'b0;
		imm_status = gtl_pkg::STS_REFUSED;
		case (in_action)
			gtl_pkg::ACT_ACQUIRE: begin
				if (cur_handle_q == 32'd0) begin
					imm_status = gtl_pkg::STS_NO_HANDLE;
				end else if (token_ctr_q == 32'd0 || token_ctr_q == gtl_pkg::WORD_MAX) begin
					imm_status = gtl_pkg::STS_EXHAUSTED;
				end else begin
					launch = 1'b1;
				end
			end
			gtl_pkg::ACT_RELEASE: begin
				launch = 1'b1;
			end
			gtl_pkg::ACT_SET: begin
				if (any_busy || cur_epoch_q == gtl_pkg::WORD_MAX) begin
					imm_status = gtl_pkg::STS_REFUSED;
				end else begin
					imm_status = gtl_pkg::STS_OK;
				end
			end
			default: begin
				imm_status = gtl_pkg::STS_REFUSED;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gtl_pkg::S_IDLE: begin
				if (accept) begin
					state_nxt = launch ? gtl_pkg::S_SCAN : gtl_pkg::S_DONE;
				end
			end
			gtl_pkg::S_SCAN: begin
				if (chain_done) begin
					state_nxt = gtl_pkg::S_DONE;
				end
			end
			gtl_pkg::S_DONE: begin
				if (load_out) begin
					state_nxt = gtl_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = gtl_pkg::S_IDLE;
			end
		endcase
	end

	// Handshake outputs.
	always_comb begin
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			gtl_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
			end
			gtl_pkg::S_DONE: begin
				load_out = !out_vld_q || m_axis_tready;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtl_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Launch register feeding the first cell; valid for one cycle only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= '0;
		end else begin
			query_q.vld <= accept && launch;
			if (accept && launch) begin
				query_q.hit <= 1'b0;
				if (in_action == gtl_pkg::ACT_ACQUIRE) begin
					query_q.acq    <= 1'b1;
					query_q.token  <= token_ctr_q;
					query_q.epoch  <= cur_epoch_q;
					query_q.handle <= cur_handle_q;
				end else begin
					query_q.acq    <= 1'b0;
					query_q.token  <= in_token;
					query_q.epoch  <= in_epoch;
					query_q.handle <= in_handle;
				end
			end
		end
	end

	// Global lease state: token counter, epoch and current handle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_ctr_q  <= 32'd1;
			cur_epoch_q  <= 32'd0;
			cur_handle_q <= 32'd0;
		end else begin
			if (accept && in_action == gtl_pkg::ACT_SET && imm_status == gtl_pkg::STS_OK) begin
				cur_handle_q <= in_handle;
				cur_epoch_q  <= cur_epoch_q + 32'd1;
			end
			if (chain_done && chain[SLOT_COUNT].acq && chain[SLOT_COUNT].hit) begin
				token_ctr_q <= token_ctr_q + 32'd1;
			end
		end
	end

	// Result stage: hold the outcome until the output register frees.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_status_q <= gtl_pkg::STS_OK;
			res_token_q  <= 32'd0;
			res_epoch_q  <= 32'd0;
			res_handle_q <= 32'd0;
		end else if (accept && !launch) begin
			res_status_q <= imm_status;
			res_token_q  <= 32'd0;
			res_epoch_q  <= 32'd0;
			res_handle_q <= 32'd0;
		end else if (state_q == gtl_pkg::S_SCAN && chain_done) begin
			res_token_q  <= 32'd0;
			res_epoch_q  <= 32'd0;
			res_handle_q <= 32'd0;
			if (chain[SLOT_COUNT].acq) begin
				if (chain[SLOT_COUNT].hit) begin
					res_status_q <= gtl_pkg::STS_OK;
					res_token_q  <= chain[SLOT_COUNT].token;
					res_epoch_q  <= chain[SLOT_COUNT].epoch;
					res_handle_q <= chain[SLOT_COUNT].handle;
				end else begin
					res_status_q <= gtl_pkg::STS_FULL;
				end
			end else begin
				res_status_q <= chain[SLOT_COUNT].hit ? gtl_pkg::STS_OK : gtl_pkg::STS_STALE;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {{(gtl_pkg::OUT_W - gtl_pkg::FIELDS_OUT_W){1'b0}},
				res_handle_q, res_epoch_q, res_token_q, res_status_q};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// Slot chain: the request advances one cell per cycle.
	assign chain[0] = query_q;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		gtl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.q_in   (chain[i]),
			.q_out  (chain[i+1]),
			.busy   (busy_vec[i])
		);
	end

endmodule

`default_nettype wire

>>> hdl/gtl_cell.sv
// One lease slot of the chain: holds busy, token, epoch and handle.
// Depends on gtl_pkg for the query struct.
`default_nettype none

module gtl_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  gtl_pkg::query_t      q_in,
	output gtl_pkg::query_t      q_out,
	output logic                 busy
);

	logic        busy_q;
	logic [31:0] token_q;
	logic [31:0] epoch_q;
	logic [31:0] handle_q;
	gtl_pkg::query_t q_out_q;
	logic        match;
	logic        take;

	assign match = (token_q == q_in.token) && (epoch_q == q_in.epoch) &&
		(handle_q == q_in.handle);
	// claim a free slot on acquire, free a matching one on release
	assign take = q_in.vld && !q_in.hit && (q_in.acq ? !busy_q : (busy_q && match));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= q_in.acq;
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_in.acq) begin
			token_q  <= q_in.token;
			epoch_q  <= q_in.epoch;
			handle_q <= q_in.handle;
		end
	end

	// pass the request on, marked hit once some slot has taken it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_out_q <= '0;
		end else begin
			q_out_q <= {q_in.vld, q_in.acq, q_in.hit | take,
				q_in.token, q_in.epoch, q_in.handle};
		end
	end

	assign q_out = q_out_q;
	assign busy  = busy_q;

endmodule

`default_nettype wire

>>> hdl/gtl_checker.sv
// Port-level checker for the lease table, bound to the top level.
// Depends on gtl_pkg and generation_tagged_lease_table_macros.svh.
`default_nettype none
`include "generation_tagged_lease_table_macros.svh"

module gtl_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_axis_tvalid,
	input wire logic                      s_axis_tready,
	input wire logic                      m_axis_tvalid,
	input wire logic                      m_axis_tready,
	input wire logic [gtl_pkg::OUT_W-1:0] m_axis_tdata
);

	logic [2:0] sts;
	logic       fields_zero;
	logic       pad_zero;

	assign sts         = m_axis_tdata[2:0];
	assign fields_zero = (m_axis_tdata[98:3] == '0);
	assign pad_zero    = (m_axis_tdata[gtl_pkg::OUT_W-1:gtl_pkg::FIELDS_OUT_W] == '0);

	// a stalled result stays offered
	`GTL_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
	// one request in flight: intake closes after an accept
	`GTL_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second request taken while busy")
	// failures never carry a grant
	`GTL_ASSERT_NEVER(a_fail_zero, m_axis_tvalid && sts != gtl_pkg::STS_OK && !fields_zero, "grant fields on failed result")
	`GTL_ASSERT_NEVER(a_status_range, m_axis_tvalid && (sts == 3'd6 || sts == 3'd7 || !pad_zero), "bad status or padding")

endmodule

bind generation_tagged_lease_table gtl_checker u_gtl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
